// ===== rtl/mgd_pkg.sv =====
// shared types, constants and helper functions for the masked grid diffusion step
// no dependencies; imported by every module of the block except mgd_ram
package mgd_pkg;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int CELLS  = GRID_W * GRID_H;
    localparam int AW     = $clog2(CELLS);
    localparam int CXW    = $clog2(GRID_W);
    localparam int CYW    = $clog2(GRID_H);
    localparam int LVW    = 32;
    localparam int KW     = 2;
    localparam int GW     = 15;
    localparam int PHW    = 3;
    localparam int WORDW  = KW + LVW;

    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 32;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SET_KIND  = 3'd1;
    localparam logic [2:0] OP_SET_LEVEL = 3'd2;
    localparam logic [2:0] OP_ADD       = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic [KW-1:0] KIND_EMPTY     = 2'd0;
    localparam logic [KW-1:0] KIND_WALL      = 2'd1;
    localparam logic [KW-1:0] KIND_GENERATOR = 2'd2;
    localparam logic [KW-1:0] KIND_VOID      = 2'd3;

    localparam logic [CFG_IW-1:0] REG_GAIN  = 1'd0;
    localparam logic [CFG_IW-1:0] REG_POWER = 1'd1;

    localparam logic [GW-1:0]  GAIN_RESET  = 15'd6554;
    localparam logic [LVW-1:0] POWER_RESET = 32'd131072;

    // sweep phases of one cell during the stencil pass
    localparam logic [PHW-1:0] PH_RD_C = 3'd0;
    localparam logic [PHW-1:0] PH_RD_L = 3'd1;
    localparam logic [PHW-1:0] PH_RD_R = 3'd2;
    localparam logic [PHW-1:0] PH_RD_U = 3'd3;
    localparam logic [PHW-1:0] PH_RD_D = 3'd4;
    localparam logic [PHW-1:0] PH_ACC  = 3'd5;
    localparam logic [PHW-1:0] PH_MUL  = 3'd6;
    localparam logic [PHW-1:0] PH_WR   = 3'd7;

    // phases of one cell during the update pass
    localparam logic [PHW-1:0] PH_AP_RD = 3'd0;
    localparam logic [PHW-1:0] PH_AP_WR = 3'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ITEM_RD,
        S_ITEM_WR,
        S_CALC,
        S_APPLY,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RS_ITEM,
        RS_CELL,
        RS_LEFT,
        RS_RIGHT,
        RS_UP,
        RS_DOWN
    } rsel_t;

    typedef struct packed {
        logic           capture;
        logic           sat_clr;
        logic           clr_wr;
        logic           mem_rd;
        rsel_t          rsel;
        logic           center_ld;
        logic           acc;
        logic           mul;
        logic           delta_wr;
        logic           delta_rd;
        logic           apply_wr;
        logic           item_exec;
        logic           out_load;
        logic [CXW-1:0] cx;
        logic [CYW-1:0] cy;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic out_free;
    } stat_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CXW-1:0] x,
                                                input logic [CYW-1:0] y);
        return AW'(y) * AW'(GRID_W) + AW'(x);
    endfunction

    // returns {saturated, clamped value}
    function automatic logic [LVW:0] clamp_level(input logic signed [34:0] v);
        logic [LVW:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111)
            r = {1'b0, v[31:0]};
        else if (v[34])
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b1, 32'h7FFF_FFFF};
        return r;
    endfunction

endpackage

// ===== rtl/mgd_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module mgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mgd_ctrl.sv =====
// controller state machine: clear pass, item sequencing, stencil and update sweeps
// depends on mgd_pkg
module mgd_ctrl
    import mgd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  stat_t stat,
    output logic  s_tready,
    output cmd_t  cmd
);

    state_t         state_reg, state_next;
    logic [PHW-1:0] phase_reg, phase_next;
    logic [CXW-1:0] cx_reg, cx_next;
    logic [CYW-1:0] cy_reg, cy_next;
    logic           last_cell;
    logic [CXW-1:0] cx_adv;
    logic [CYW-1:0] cy_adv;

    assign last_cell = (cx_reg == CXW'(GRID_W - 1)) && (cy_reg == CYW'(GRID_H - 1));

    always_comb
    begin
        if (cx_reg == CXW'(GRID_W - 1))
        begin
            cx_adv = '0;
            cy_adv = cy_reg + CYW'(1);
        end
        else
        begin
            cx_adv = cx_reg + CXW'(1);
            cy_adv = cy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
        end
    end

    // next state and sweep counters
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (last_cell)
                begin
                    state_next = S_IDLE;
                    cx_next    = '0;
                    cy_next    = '0;
                end
                else
                begin
                    cx_next = cx_adv;
                    cy_next = cy_adv;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ITEM_RD;
                end
            end
            S_ITEM_RD:
            begin
                phase_next = '0;
                state_next = stat.is_tick ? S_CALC : S_ITEM_WR;
            end
            S_ITEM_WR:
            begin
                state_next = S_DONE;
            end
            S_CALC:
            begin
                if (phase_reg == PH_WR)
                begin
                    phase_next = '0;
                    if (last_cell)
                    begin
                        state_next = S_APPLY;
                        cx_next    = '0;
                        cy_next    = '0;
                    end
                    else
                    begin
                        cx_next = cx_adv;
                        cy_next = cy_adv;
                    end
                end
                else
                begin
                    phase_next = phase_reg + PHW'(1);
                end
            end
            S_APPLY:
            begin
                if (phase_reg == PH_AP_WR)
                begin
                    phase_next = '0;
                    if (last_cell)
                    begin
                        state_next = S_DONE;
                        cx_next    = '0;
                        cy_next    = '0;
                    end
                    else
                    begin
                        cx_next = cx_adv;
                        cy_next = cy_adv;
                    end
                end
                else
                begin
                    phase_next = PH_AP_WR;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        cmd.rsel = RS_ITEM;
        cmd.cx   = cx_reg;
        cmd.cy   = cy_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_ITEM_RD:
            begin
                cmd.sat_clr = 1'b1;
                cmd.mem_rd  = 1'b1;
                cmd.rsel    = RS_ITEM;
            end
            S_ITEM_WR:
            begin
                cmd.item_exec = 1'b1;
            end
            S_CALC:
            begin
                unique case (phase_reg)
                    PH_RD_C:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rsel   = RS_CELL;
                    end
                    PH_RD_L:
                    begin
                        cmd.mem_rd    = 1'b1;
                        cmd.rsel      = RS_LEFT;
                        cmd.center_ld = 1'b1;
                    end
                    PH_RD_R:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rsel   = RS_RIGHT;
                        cmd.acc    = 1'b1;
                    end
                    PH_RD_U:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rsel   = RS_UP;
                        cmd.acc    = 1'b1;
                    end
                    PH_RD_D:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rsel   = RS_DOWN;
                        cmd.acc    = 1'b1;
                    end
                    PH_ACC:
                    begin
                        cmd.acc = 1'b1;
                    end
                    PH_MUL:
                    begin
                        cmd.mul = 1'b1;
                    end
                    PH_WR:
                    begin
                        cmd.delta_wr = 1'b1;
                    end
                    default:
                    begin
                        cmd.mul = 1'b0;
                    end
                endcase
            end
            S_APPLY:
            begin
                if (phase_reg == PH_AP_RD)
                begin
                    cmd.mem_rd   = 1'b1;
                    cmd.rsel     = RS_CELL;
                    cmd.delta_rd = 1'b1;
                end
                else
                begin
                    cmd.apply_wr = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while an item is in progress");

    a_calc_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && phase_reg == PH_WR && last_cell) |=> state_reg == S_APPLY)
        else $error("stencil pass did not hand over to update pass");

    a_item_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITEM_WR) |-> $past(state_reg == S_ITEM_RD))
        else $error("item write without preceding cell read");
`endif

endmodule

// ===== rtl/mgd_datapath.sv =====
// datapath: cell and delta memories, stencil arithmetic, item edits, result register
// depends on mgd_pkg and mgd_ram
module mgd_datapath
    import mgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                m_tready,
    output stat_t               stat,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [2:0]        op_reg;
    logic [5:0]        ix_reg;
    logic [5:0]        iy_reg;
    logic [KW-1:0]     nkind_reg;
    logic [LVW-1:0]    amount_reg;

    logic [GW-1:0]     gain_reg;
    logic [LVW-1:0]    power_reg;

    logic [LVW-1:0]    center_reg;
    logic [KW-1:0]     ckind_reg;
    logic signed [34:0] sum_reg;
    logic signed [50:0] prod_reg;
    logic              nb_ok_reg;
    logic              sat_reg;
    logic [LVW-1:0]    res_level_reg;
    logic [KW-1:0]     res_kind_reg;

    logic              out_valid_reg;
    logic [LVW-1:0]    out_level_reg;
    logic [KW-1:0]     out_kind_reg;
    logic              out_sat_reg;

    logic              in_grid;
    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     cell_a;
    logic [AW-1:0]     rd_addr;
    logic              rd_ok;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORDW-1:0]  mem_wdata;
    logic [WORDW-1:0]  rd_word;
    logic [LVW-1:0]    rd_level;
    logic [KW-1:0]     rd_kind;
    logic [LVW-1:0]    delta_rd_data;
    logic [LVW:0]      add_res;
    logic [LVW:0]      apply_res;
    logic [LVW:0]      delta_res;
    logic signed [34:0] shifted;
    logic signed [34:0] delta_raw;
    logic              item_write;

    assign in_grid   = (int'(ix_reg) < GRID_W) && (int'(iy_reg) < GRID_H);
    assign item_addr = cell_addr(CXW'(ix_reg), CYW'(iy_reg));
    assign cell_a    = cell_addr(cmd.cx, cmd.cy);
    assign rd_level  = rd_word[LVW-1:0];
    assign rd_kind   = rd_word[WORDW-1:LVW];

    // read address and in-grid flag of the item cell, sweep cell or neighbor being fetched
    always_comb
    begin
        rd_addr = item_addr;
        rd_ok   = 1'b1;
        unique case (cmd.rsel)
            RS_ITEM:
            begin
                rd_addr = item_addr;
            end
            RS_CELL:
            begin
                rd_addr = cell_a;
            end
            RS_LEFT:
            begin
                rd_addr = cell_addr(cmd.cx - CXW'(1), cmd.cy);
                rd_ok   = cmd.cx != '0;
            end
            RS_RIGHT:
            begin
                rd_addr = cell_addr(cmd.cx + CXW'(1), cmd.cy);
                rd_ok   = cmd.cx != CXW'(GRID_W - 1);
            end
            RS_UP:
            begin
                rd_addr = cell_addr(cmd.cx, cmd.cy - CYW'(1));
                rd_ok   = cmd.cy != '0;
            end
            RS_DOWN:
            begin
                rd_addr = cell_addr(cmd.cx, cmd.cy + CYW'(1));
                rd_ok   = cmd.cy != CYW'(GRID_H - 1);
            end
            default:
            begin
                rd_ok = 1'b0;
            end
        endcase
    end

    assign add_res   = clamp_level({{3{rd_level[31]}}, rd_level}
                                   + {{3{amount_reg[31]}}, amount_reg});
    assign apply_res = clamp_level({{3{rd_level[31]}}, rd_level}
                                   + {{3{delta_rd_data[31]}}, delta_rd_data});

    // floor shift of the Q19.32 product back to Q19.16, clamped later to Q16.16
    assign shifted = prod_reg[50:16];

    always_comb
    begin
        case (ckind_reg)
            KIND_GENERATOR: delta_raw = shifted + {{3{power_reg[31]}}, power_reg};
            KIND_EMPTY:     delta_raw = shifted;
            default:        delta_raw = '0;
        endcase
    end

    assign delta_res = clamp_level(delta_raw);

    assign item_write = cmd.item_exec && in_grid
                        && (op_reg == OP_SET_KIND || op_reg == OP_SET_LEVEL
                            || op_reg == OP_ADD);

    always_comb
    begin
        mem_we    = cmd.clr_wr || cmd.apply_wr || item_write;
        mem_waddr = cell_a;
        mem_wdata = '0;
        if (cmd.apply_wr)
        begin
            mem_wdata = {rd_kind, apply_res[LVW-1:0]};
        end
        else if (item_write)
        begin
            mem_waddr = item_addr;
            case (op_reg)
                OP_SET_KIND:  mem_wdata = {nkind_reg, rd_level};
                OP_SET_LEVEL: mem_wdata = {rd_kind, amount_reg};
                default:      mem_wdata = {rd_kind, add_res[LVW-1:0]};
            endcase
        end
    end

    mgd_ram #(
        .WIDTH(WORDW),
        .DEPTH(CELLS)
    ) u_cell_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (cmd.mem_rd),
        .raddr(rd_addr),
        .rdata(rd_word)
    );

    mgd_ram #(
        .WIDTH(LVW),
        .DEPTH(CELLS)
    ) u_delta_ram (
        .clk  (clk),
        .we   (cmd.delta_wr),
        .waddr(cell_a),
        .wdata(delta_res[LVW-1:0]),
        .re   (cmd.delta_rd),
        .raddr(cell_a),
        .rdata(delta_rd_data)
    );

    // item fields, stencil working registers, read result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= s_tuser;
            ix_reg     <= s_tdata[5:0];
            iy_reg     <= s_tdata[11:6];
            nkind_reg  <= s_tdata[13:12];
            amount_reg <= s_tdata[45:14];
        end
        if (cmd.mem_rd)
        begin
            nb_ok_reg <= rd_ok;
        end
        if (cmd.center_ld)
        begin
            center_reg <= rd_level;
            ckind_reg  <= rd_kind;
            sum_reg    <= '0;
        end
        else if (cmd.acc && nb_ok_reg && rd_kind != KIND_WALL)
        begin
            sum_reg <= sum_reg + {{3{rd_level[31]}}, rd_level}
                       - {{3{center_reg[31]}}, center_reg};
        end
        if (cmd.mul)
        begin
            prod_reg <= sum_reg * $signed({1'b0, gain_reg});
        end
        if (cmd.sat_clr)
        begin
            res_level_reg <= '0;
            res_kind_reg  <= '0;
        end
        else if (cmd.item_exec && in_grid && op_reg == OP_READ)
        begin
            res_level_reg <= rd_level;
            res_kind_reg  <= rd_kind;
        end
        if (cmd.out_load)
        begin
            out_level_reg <= res_level_reg;
            out_kind_reg  <= res_kind_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            power_reg     <= POWER_RESET;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_GAIN)
            begin
                gain_reg <= cfg_data[GW-1:0];
            end
            if (cfg_we && cfg_index == REG_POWER)
            begin
                power_reg <= cfg_data;
            end
            if (cmd.sat_clr)
            begin
                sat_reg <= 1'b0;
            end
            else if ((item_write && op_reg == OP_ADD && add_res[LVW])
                     || (cmd.delta_wr && delta_res[LVW])
                     || (cmd.apply_wr && apply_res[LVW]))
            begin
                sat_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_tick  = op_reg == OP_TICK;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {5'b0, out_sat_reg, out_kind_reg, out_level_reg};

endmodule

// ===== rtl/masked_grid_diffusion_step.sv =====
// top level of the masked grid diffusion step: controller plus datapath
// depends on mgd_pkg, mgd_ctrl, mgd_datapath (and mgd_ram below it)
//
//   channel  direction  handshake           payload
//   s_*      in         s_tvalid/s_tready   s_tuser operation, s_tdata cell and amount
//   m_*      out        m_tvalid/m_tready   m_tdata level, kind, saturated
//   cfg_*    in         cfg_we              cfg_index, cfg_data
//
// after reset a clearing pass writes every cell with s_tready low
// edits and reads pass S_ITEM_RD and S_ITEM_WR to S_DONE, which loads the result
// into the output register on m_tdata once it is free; the next transaction is taken in S_IDLE
// a tick runs a stencil pass (read cell, neighbors, accumulate, multiply, write delta),
// then an update pass (read, write) per cell, paced by the cell memory's single read port
// one item at a time; a result waits in the output register while the next item is taken
module masked_grid_diffusion_step
    import mgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cell_x[5:0], cell_y[11:6], new_kind[13:12], amount[45:14], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation[2:0]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // level_out[31:0], kind_out[33:32], saturated[34], zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    mgd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .stat    (stat),
        .s_tready(s_tready),
        .cmd     (cmd)
    );

    mgd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== dv/grid_step_checker.sv =====
// checker for the masked grid diffusion step: keeps its own copy of the grid,
// predicts one result per input transaction and compares output transactions
// depends on mgd_pkg for widths and codes
module grid_step_checker
    import mgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LVW-1:0] level;
        logic [KW-1:0]  kind;
        logic           sat;
    } cell_result_t;

    logic signed [LVW-1:0] grid_level [CELLS];
    logic [KW-1:0]         grid_kind  [CELLS];
    logic signed [LVW-1:0] grid_delta [CELLS];
    logic [GW-1:0]         gain;
    logic signed [LVW-1:0] power;
    cell_result_t          result_fifo [$];

    assign pending = result_fifo.size();

    function automatic logic signed [LVW-1:0] clamp32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic floodable(input int x, input int y);
        if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H)
            return 1'b0;
        return grid_kind[y * GRID_W + x] != KIND_WALL;
    endfunction

    // all deltas from the old levels first, then the saturating update
    function automatic logic diffuse_grid();
        logic sat;
        int idx;
        int nx, ny;
        longint center, sum, delta;
        sat = 1'b0;
        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
            begin
                idx = y * GRID_W + x;
                delta = 0;
                if (grid_kind[idx] != KIND_WALL)
                begin
                    center = grid_level[idx];
                    sum = 0;
                    for (int d = 0; d < 4; d++)
                    begin
                        nx = x + ((d == 0) ? -1 : (d == 1) ? 1 : 0);
                        ny = y + ((d == 2) ? -1 : (d == 3) ? 1 : 0);
                        if (floodable(nx, ny))
                            sum += longint'(grid_level[ny * GRID_W + nx]) - center;
                    end
                    // arithmetic shift floors toward minus infinity
                    delta = (sum * longint'({1'b0, gain})) >>> 16;
                    if (grid_kind[idx] == KIND_GENERATOR)
                        delta += longint'(power);
                    else if (grid_kind[idx] == KIND_VOID)
                        delta = 0;
                end
                grid_delta[idx] = clamp32(delta, sat);
            end
        for (int i = 0; i < CELLS; i++)
            grid_level[i] = clamp32(longint'(grid_level[i]) + longint'(grid_delta[i]), sat);
        return sat;
    endfunction

    function automatic cell_result_t apply_item(input logic [S_USER_W-1:0] op,
                                                input logic [S_DATA_W-1:0] d);
        cell_result_t r;
        int idx;
        logic sat;
        r = '0;
        sat = 1'b0;
        idx = int'(d[11:6]) * GRID_W + int'(d[5:0]);
        case (op)
            OP_TICK:      sat = diffuse_grid();
            OP_SET_KIND:  grid_kind[idx] = d[13:12];
            OP_SET_LEVEL: grid_level[idx] = d[45:14];
            OP_ADD:       grid_level[idx] = clamp32(longint'(grid_level[idx])
                                                    + longint'($signed(d[45:14])), sat);
            OP_READ:
            begin
                r.level = grid_level[idx];
                r.kind  = grid_kind[idx];
            end
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_r, got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                grid_level[i] = '0;
                grid_kind[i]  = KIND_EMPTY;
                grid_delta[i] = '0;
            end
            gain = GAIN_RESET;
            power = POWER_RESET;
            result_fifo.delete();
            errors = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.level = m_tdata[31:0];
                got.kind  = m_tdata[33:32];
                got.sat   = m_tdata[34];
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result level=%h kind=%0d sat=%0b",
                             $realtime, got.level, got.kind, got.sat);
                    errors++;
                end
                else
                begin
                    exp_r = result_fifo.pop_front();
                    if (got.level !== exp_r.level)
                    begin
                        $display("%0t: level_out expected %h actual %h",
                                 $realtime, exp_r.level, got.level);
                        errors++;
                    end
                    if (got.kind !== exp_r.kind)
                    begin
                        $display("%0t: kind_out expected %0d actual %0d",
                                 $realtime, exp_r.kind, got.kind);
                        errors++;
                    end
                    if (got.sat !== exp_r.sat)
                    begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $realtime, exp_r.sat, got.sat);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                result_fifo.push_back(apply_item(s_tuser, s_tdata));
            if (cfg_we)
            begin
                if (cfg_index == REG_GAIN)
                    gain = cfg_data[GW-1:0];
                else if (cfg_index == REG_POWER)
                    power = cfg_data;
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// top of the masked grid diffusion step testbench: clock, reset, stimulus and verdict
// depends on mgd_pkg, grid_step_checker and the block's RTL
module testbench;
    import mgd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;
    int                  errors;
    int                  pending;
    int                  tick_budget;

    masked_grid_diffusion_step DUT (.*);

    grid_step_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // drives one input transaction and returns once it is accepted; valid stays high
    task automatic send_item(input logic [2:0] op, input int x, input int y,
                             input logic [1:0] kind, input logic [31:0] amount);
        int gap;
        gap = $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, amount, kind, 6'(y), 6'(x)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        s_tvalid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic random_item();
        logic [2:0] op;
        logic [31:0] amount;
        int x, y, pick;
        pick = $urandom_range(0, 99);
        if (pick < 4 && tick_budget > 0)
        begin
            op = OP_TICK;
            tick_budget--;
        end
        else if (pick < 7)
            op = 3'($urandom_range(5, 7));
        else
            op = 3'($urandom_range(1, 4));
        // mostly a small corner so edits, reads and ticks interact
        if ($urandom_range(0, 3) == 0)
        begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
        end
        else
        begin
            x = $urandom_range(0, 4);
            y = $urandom_range(0, 4);
        end
        if ($urandom_range(0, 1))
            amount = $urandom();
        else
            amount = 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
        send_item(op, x, y, 2'($urandom_range(0, 3)), amount);
    endtask

    // receiver: random stalls, and one long hold-off to back up the block
    initial
    begin
        int gap, taken;
        m_tready = 1'b0;
        taken = 0;
        forever
        begin
            gap = (taken == 40) ? 300 : $urandom_range(0, 10);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        cfg_we    = 1'b0;
        cfg_index = REG_GAIN;
        cfg_data  = '0;
        tick_budget = 8;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: kinds, level extremes, saturating adds, unknown codes, ticks
        send_item(OP_SET_KIND, 0, 0, KIND_GENERATOR, '0);
        send_item(OP_SET_KIND, 1, 0, KIND_WALL, '0);
        send_item(OP_SET_KIND, 2, 0, KIND_VOID, '0);
        send_item(OP_SET_KIND, 3, 0, KIND_EMPTY, 32'hFFFF_FFFF);
        send_item(OP_SET_LEVEL, 63, 63, KIND_EMPTY, 32'h7FFF_FFFF);
        send_item(OP_ADD, 63, 63, KIND_EMPTY, 32'h0000_0001);
        send_item(OP_SET_LEVEL, 0, 63, KIND_EMPTY, 32'h8000_0000);
        send_item(OP_ADD, 0, 63, KIND_EMPTY, 32'hFFFF_FFFF);
        send_item(OP_SET_LEVEL, 2, 1, KIND_EMPTY, 32'h0003_0000);
        send_item(OP_SET_LEVEL, 2, 0, KIND_EMPTY, 32'h0001_0000);
        send_item(OP_READ, 63, 63, KIND_EMPTY, '0);
        send_item(OP_READ, 0, 63, KIND_EMPTY, '0);
        send_item(OP_READ, 1, 0, KIND_EMPTY, '0);
        send_item(3'd5, 5, 5, KIND_VOID, 32'h1234_5678);
        send_item(3'd6, 63, 0, KIND_WALL, 32'hFFFF_FFFF);
        send_item(3'd7, 0, 63, KIND_GENERATOR, 32'h8000_0000);
        send_item(OP_TICK, 0, 0, KIND_EMPTY, '0);
        send_item(OP_READ, 0, 0, KIND_EMPTY, '0);
        send_item(OP_READ, 2, 0, KIND_EMPTY, '0);
        send_item(OP_READ, 2, 1, KIND_EMPTY, '0);
        send_item(OP_READ, 62, 63, KIND_EMPTY, '0);
        // generator set near the top of the range, then ticked and read back
        send_item(OP_SET_LEVEL, 0, 0, KIND_EMPTY, 32'h7FFF_0000);
        send_item(OP_TICK, 0, 0, KIND_EMPTY, '0);
        send_item(OP_READ, 0, 0, KIND_EMPTY, '0);
        drain_results();

        // random phases over several register settings, extremes among them
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_GAIN, 32'd0);
                    write_reg(REG_POWER, 32'h7FFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_GAIN, 32'd16384);
                    write_reg(REG_POWER, 32'h8000_0000);
                end
                2:
                begin
                    write_reg(REG_GAIN, 32'd32767);
                    write_reg(REG_POWER, 32'd0);
                end
                default:
                begin
                    write_reg(REG_GAIN, 32'($urandom_range(0, 16384)));
                    write_reg(REG_POWER, $urandom());
                end
            endcase
            tick_budget = 2;
            for (int n = 0; n < 25; n++)
                random_item();
            send_item(OP_TICK, 0, 0, KIND_EMPTY, '0);
            for (int n = 0; n < 5; n++)
                random_item();
            drain_results();
        end

        repeat (50) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
